// File: rtl/core/gags_pkg.sv
// Package for the genotype allele group summer.
// Field widths, limits, register indexes and item/entry types.
// Depends on nothing; imported by every module of the core but gags_ram.
`timescale 1ns / 1ps
`default_nettype none

package gags_pkg;

  localparam int MAX_GROUPS = 8;
  localparam int NUM_LEVELS = 4;
  localparam int GIDX_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int LEVEL_W    = 2;
  localparam int CODE_W     = 8;
  localparam int LABEL_W    = 8;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 17;
  localparam int NGRP_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [LEVEL_W-1:0] LEVEL_MISSING = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE   = 2'd3;

  localparam logic [31:0]         LEVEL_CODES_RST   = 32'h0302_0100;
  localparam logic [NGRP_W-1:0]   GROUPS_IN_USE_RST = 4'd2;
  localparam logic [SUM_W-1:0]    SUM_MAX           = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX           = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_CODES   = 2'd0,
    CFG_SUM_ENABLE    = 2'd1,
    CFG_GROUP_LABELS  = 2'd2,
    CFG_GROUPS_IN_USE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0]  genotype_code;
    logic [LABEL_W-1:0] subject_group;
    logic               last_subject;
  } gags_in_t;

  typedef struct packed {
    logic [2:0]       group_index;
    logic [SUM_W-1:0] allele_sum;
    logic [CNT_W-1:0] called_count;
    logic             inverted;
    logic             last_of_probe;
  } gags_out_t;

  // One group's accumulators, one RAM word
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] called;
    logic [CNT_W-1:0] lvl_one;
    logic [CNT_W-1:0] lvl_three;
  } gags_entry_t;

  // Per-entry control from the sweep sequencer to the update logic
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               in_range;
    logic               label_hit;
    logic               last;
    logic               inv;
    logic               sum_en;
    logic               is_final;
    logic [GIDX_W-1:0]  gidx;
  } gags_upd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/genotype_allele_group_summer_core.sv
// Top level of the genotype allele group summer: config registers, probe
// counters, group sweep sequencer over the accumulator RAM.
// Depends on gags_pkg, gags_ram, gags_level_map, gags_group_update.
//
//   channel | ports                           | handshake
//   --------+---------------------------------+--------------------------------
//   input   | start, busy, in_data            | taken when start && !busy
//   result  | out_valid, out_data             | one-cycle strobe, no stall
//   config  | cfg_we, cfg_index, cfg_wdata    | write when cfg_we, no wait
//
// An item without the end mark is taken together with the read of group 0,
// then gets one RAM read-modify-write per group in use, one entry per cycle
// through the single write port. An item with the end mark sweeps all
// MAX_GROUPS entries so the accumulators are cleared; with summing on its
// results come out one per cycle, one per group in use, and with summing off
// a single result comes out. busy is high for the whole sweep.
// Reset clears the entry valid bits at once, so no clearing pass is needed;
// an entry never written since reset reads as zero. Results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module genotype_allele_group_summer_core
  import gags_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire gags_in_t              in_data,
  output logic                       out_valid,
  output gags_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

  // configuration
  logic [31:0]                 level_codes_r;
  logic                        sum_enable_r;
  logic [MAX_GROUPS*8-1:0]     group_labels_r;
  logic [NGRP_W-1:0]           groups_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_codes_r   <= LEVEL_CODES_RST;
      sum_enable_r    <= 1'b1;
      group_labels_r  <= '0;
      groups_in_use_r <= GROUPS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEVEL_CODES:   level_codes_r   <= cfg_wdata[31:0];
        CFG_SUM_ENABLE:    sum_enable_r    <= cfg_wdata[0];
        CFG_GROUP_LABELS:  group_labels_r  <= cfg_wdata[MAX_GROUPS*8-1:0];
        CFG_GROUPS_IN_USE: groups_in_use_r <= cfg_wdata[NGRP_W-1:0];
      endcase
    end
  end

  // groups in use, clamped to 1..MAX_GROUPS
  logic [NGRP_W-1:0] n_eff;
  always_comb begin
    priority if (groups_in_use_r == '0) begin
      n_eff = NGRP_W'(1);
    end else if (groups_in_use_r > NGRP_W'(MAX_GROUPS)) begin
      n_eff = NGRP_W'(MAX_GROUPS);
    end else begin
      n_eff = groups_in_use_r;
    end
  end

  // input level mapping
  logic [LEVEL_W-1:0] in_level;
  logic               in_is_one;
  logic               in_is_three;

  gags_level_map u_level_map (
    .code        (in_data.genotype_code),
    .level_codes (level_codes_r),
    .level       (in_level),
    .is_one      (in_is_one),
    .is_three    (in_is_three)
  );

  // sequencer and probe state
  state_t              state_r;
  logic [GIDX_W-1:0]   k_r;
  logic [GIDX_W-1:0]   last_k_r;
  logic [NGRP_W-1:0]   n_r;
  logic [LEVEL_W-1:0]  level_r;
  logic [LABEL_W-1:0]  label_r;
  logic                last_r;
  logic                inv_r;
  logic [CNT_W-1:0]    probe_one_r;
  logic [CNT_W-1:0]    probe_three_r;
  logic [CNT_W-1:0]    probe_one_nxt;
  logic [CNT_W-1:0]    probe_three_nxt;
  logic                out_valid_r;
  gags_out_t           out_data_r;
  logic [MAX_GROUPS-1:0] ent_valid_r;
  logic                ent_vld_q_r;

  logic                accept;
  logic                sweeping;

  assign sweeping = (state_r == ST_SWEEP);
  assign busy     = sweeping;
  assign accept   = start && !busy;

  always_comb begin
    probe_one_nxt   = probe_one_r;
    probe_three_nxt = probe_three_r;
    if (in_is_one && (probe_one_r != CNT_MAX)) begin
      probe_one_nxt = probe_one_r + CNT_W'(1);
    end
    if (in_is_three && (probe_three_r != CNT_MAX)) begin
      probe_three_nxt = probe_three_r + CNT_W'(1);
    end
  end

  // RAM access: read one entry ahead of the modify/write index
  logic [GIDX_W-1:0] rd_addr;
  gags_entry_t       rd_word;
  gags_entry_t       rd_entry;
  gags_entry_t       wr_entry;
  gags_upd_ctl_t     upd_ctl;
  gags_out_t         upd_res;
  logic              upd_emit;

  assign rd_addr  = sweeping ? (k_r + GIDX_W'(1)) : '0;
  assign rd_entry = ent_vld_q_r ? rd_word : '0;

  gags_ram #(
    .WIDTH ($bits(gags_entry_t)),
    .DEPTH (MAX_GROUPS)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (sweeping),
    .wr_addr (k_r),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_comb begin
    upd_ctl.level     = level_r;
    upd_ctl.in_range  = (NGRP_W'(k_r) < n_r);
    upd_ctl.label_hit = (group_labels_r[{k_r, 3'b000} +: 8] == label_r);
    upd_ctl.last      = last_r;
    upd_ctl.inv       = inv_r;
    upd_ctl.sum_en    = sum_enable_r;
    upd_ctl.is_final  = (NGRP_W'(k_r) + NGRP_W'(1) == n_r);
    upd_ctl.gidx      = k_r;
  end

  gags_group_update u_update (
    .entry_in  (rd_entry),
    .ctl       (upd_ctl),
    .entry_out (wr_entry),
    .result    (upd_res),
    .emit      (upd_emit)
  );

  // item latch, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      level_r <= in_level;
      label_r <= in_data.subject_group;
      last_r  <= in_data.last_subject;
      n_r     <= n_eff;
      inv_r   <= (probe_three_nxt > probe_one_nxt);
    end
    out_data_r  <= upd_res;
    // data in the RAM is valid only once written since reset
    ent_vld_q_r <= ent_valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      k_r           <= '0;
      last_k_r      <= '0;
      probe_one_r   <= '0;
      probe_three_r <= '0;
      out_valid_r   <= 1'b0;
      ent_valid_r   <= '0;
    end else begin
      out_valid_r <= sweeping && upd_emit;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SWEEP;
            k_r     <= '0;
            // end of probe sweeps every entry to clear it
            last_k_r <= in_data.last_subject ? GIDX_W'(MAX_GROUPS - 1)
                                             : GIDX_W'(n_eff - NGRP_W'(1));
            if (in_data.last_subject) begin
              probe_one_r   <= '0;
              probe_three_r <= '0;
            end else begin
              probe_one_r   <= probe_one_nxt;
              probe_three_r <= probe_three_nxt;
            end
          end
        end
        ST_SWEEP: begin
          ent_valid_r[k_r] <= 1'b1;
          k_r <= k_r + GIDX_W'(1);
          if (k_r == last_k_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // results only come out of a sweep
  a_out_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SWEEP))
    else $error("result strobe without a sweep");

  // probe counters are cleared once the end-of-probe item is taken
  a_probe_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_subject) |=> (probe_one_r == '0 && probe_three_r == '0))
    else $error("probe counters not cleared at probe end");

  // the final result of a probe is never directly followed by another
  a_final_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_probe) |=> !out_valid)
    else $error("result after last_of_probe");

  // an accepted item always starts a sweep
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && k_r == '0))
    else $error("accepted item did not start a sweep");

endmodule

`default_nettype wire

// File: rtl/core/gags_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-group accumulators in this core.
`timescale 1ns / 1ps
`default_nettype none

module gags_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/gags_level_map.sv
// Maps a raw genotype byte to a level by the configured level codes.
// Depends on gags_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gags_level_map
  import gags_pkg::*;
(
  input  wire logic [CODE_W-1:0]           code,
  input  wire logic [NUM_LEVELS*CODE_W-1:0] level_codes,
  output logic      [LEVEL_W-1:0]           level,
  output logic                              is_one,
  output logic                              is_three
);

  // highest matching level wins; no match is missing
  always_comb begin
    level = LEVEL_MISSING;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (code == level_codes[l*CODE_W +: CODE_W]) begin
        level = LEVEL_W'(l);
      end
    end
  end

  assign is_one   = (code == level_codes[32'(LEVEL_ONE)*CODE_W +: CODE_W]);
  assign is_three = (code == level_codes[32'(LEVEL_THREE)*CODE_W +: CODE_W]);

endmodule

`default_nettype wire

// File: rtl/core/gags_group_update.sv
// Modify step of the read-modify-write on one group entry: saturating
// accumulate, swap on inversion, result build and clear at probe end.
// Depends on gags_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gags_group_update
  import gags_pkg::*;
(
  input  wire gags_entry_t   entry_in,
  input  wire gags_upd_ctl_t ctl,
  output gags_entry_t        entry_out,
  output gags_out_t          result,
  output logic               emit
);

  gags_entry_t              upd;
  logic                     acc_en;
  logic [SUM_W:0]           sum_add;
  logic [CNT_W:0]           called_add;
  logic [CNT_W:0]           one_add;
  logic [CNT_W:0]           three_add;
  logic signed [SUM_W+2:0]  swapped;
  logic [SUM_W-1:0]         sum_res;

  assign acc_en = ctl.in_range && ctl.label_hit && (ctl.level != LEVEL_MISSING);

  always_comb begin
    sum_add    = {1'b0, entry_in.sum} + (SUM_W+1)'(ctl.level - LEVEL_ONE);
    called_add = {1'b0, entry_in.called} + (CNT_W+1)'(1);
    one_add    = {1'b0, entry_in.lvl_one} + (CNT_W+1)'(1);
    three_add  = {1'b0, entry_in.lvl_three} + (CNT_W+1)'(1);
    upd = entry_in;
    if (acc_en) begin
      upd.sum    = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      upd.called = called_add[CNT_W] ? CNT_MAX : called_add[CNT_W-1:0];
      if (ctl.level == LEVEL_ONE) begin
        upd.lvl_one = one_add[CNT_W] ? CNT_MAX : one_add[CNT_W-1:0];
      end
      if (ctl.level == LEVEL_THREE) begin
        upd.lvl_three = three_add[CNT_W] ? CNT_MAX : three_add[CNT_W-1:0];
      end
    end
  end

  // levels one and three swapped: sum + 2*(c1 - c3), clamped
  always_comb begin
    swapped = $signed({3'b000, upd.sum}) + $signed({3'b000, upd.lvl_one, 1'b0})
            - $signed({3'b000, upd.lvl_three, 1'b0});
    priority if (!ctl.inv) begin
      sum_res = upd.sum;
    end else if (swapped[SUM_W+2]) begin
      sum_res = '0;
    end else if (swapped[SUM_W+1:SUM_W] != 2'b00) begin
      sum_res = SUM_MAX;
    end else begin
      sum_res = swapped[SUM_W-1:0];
    end
  end

  always_comb begin
    result = '0;
    result.inverted = ctl.inv;
    if (ctl.sum_en) begin
      result.group_index   = 3'(ctl.gidx);
      result.allele_sum    = sum_res;
      result.called_count  = upd.called;
      result.last_of_probe = ctl.is_final;
      emit = ctl.last && ctl.in_range;
    end else begin
      result.last_of_probe = 1'b1;
      emit = ctl.last && (ctl.gidx == '0);
    end
  end

  assign entry_out = ctl.last ? '0 : upd;

endmodule

`default_nettype wire

// File: sim/genotype_allele_group_summer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for genotype_allele_group_summer_core: directed probes, one longer
// full-rate probe, then random probes under changing register settings.
// Depends on gags_pkg and the core RTL; the checker class lives in this module.

module genotype_allele_group_summer_core_tb;
  import gags_pkg::*;

  localparam int LIMIT_CYCLES  = 100_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_PROBE    = 24;      // level-3 heavy, so the swap kicks in
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 45;
  localparam int SHOWN_ERRORS  = 10;

  // Tracks registers and accumulators, predicts the result burst of each probe and
  // compares every result strobe with the oldest prediction.
  class allele_sum_checker;
    logic [31:0]       level_codes;
    logic              sum_en;
    logic [63:0]       labels;
    logic [NGRP_W-1:0] ngrp;
    logic [SUM_W-1:0]  grp_sum[MAX_GROUPS];
    logic [CNT_W-1:0]  grp_called[MAX_GROUPS];
    logic [CNT_W-1:0]  grp_one[MAX_GROUPS];
    logic [CNT_W-1:0]  grp_three[MAX_GROUPS];
    logic [CNT_W-1:0]  probe_one;
    logic [CNT_W-1:0]  probe_three;
    gags_out_t         pending_sums[$];
    int                errors;

    function new();
      level_codes = LEVEL_CODES_RST;
      sum_en      = 1'b1;
      labels      = '0;
      ngrp        = GROUPS_IN_USE_RST;
      errors      = 0;
      clear_tallies();
    endfunction

    function void clear_tallies();
      foreach (grp_sum[k]) begin
        grp_sum[k]    = '0;
        grp_called[k] = '0;
        grp_one[k]    = '0;
        grp_three[k]  = '0;
      end
      probe_one   = '0;
      probe_three = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_LEVEL_CODES:   level_codes = val[31:0];
        CFG_SUM_ENABLE:    sum_en      = val[0];
        CFG_GROUP_LABELS:  labels      = val;
        CFG_GROUPS_IN_USE: ngrp        = val[NGRP_W-1:0];
        default: ;
      endcase
    endfunction

    // 0 behaves as 1, anything past MAX_GROUPS as MAX_GROUPS
    function int live_groups();
      if (ngrp == 0) return 1;
      if (ngrp > MAX_GROUPS) return MAX_GROUPS;
      return int'(ngrp);
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void note_subject(gags_in_t it);
      logic [LEVEL_W-1:0] lvl;
      logic               inv;
      gags_out_t          want;
      int                 n;
      int                 s;
      int                 l;
      int                 k;
      n   = live_groups();
      lvl = LEVEL_MISSING;
      // highest matching level wins; no match stays missing
      for (l = 0; l < NUM_LEVELS; l++)
        if (it.genotype_code == level_codes[8*l +: 8]) lvl = LEVEL_W'(l);
      if (it.genotype_code == level_codes[8*LEVEL_ONE +: 8]) probe_one = bump(probe_one);
      if (it.genotype_code == level_codes[8*LEVEL_THREE +: 8])
        probe_three = bump(probe_three);
      if (lvl != LEVEL_MISSING) begin
        for (k = 0; k < n; k++) begin
          if (labels[8*k +: 8] == it.subject_group) begin
            s = int'(grp_sum[k]) + int'(lvl) - 1;
            grp_sum[k]    = (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
            grp_called[k] = bump(grp_called[k]);
            if (lvl == LEVEL_ONE) grp_one[k] = bump(grp_one[k]);
            if (lvl == LEVEL_THREE) grp_three[k] = bump(grp_three[k]);
          end
        end
      end
      if (!it.last_subject) return;

      inv = (probe_three > probe_one);
      if (!sum_en) begin
        want = '0;
        want.inverted      = inv;
        want.last_of_probe = 1'b1;
        pending_sums.push_back(want);
      end else begin
        for (k = 0; k < n; k++) begin
          // swap of levels 1 and 3 moves the sum by twice their difference
          s = int'(grp_sum[k]);
          if (inv) s += 2 * (int'(grp_one[k]) - int'(grp_three[k]));
          if (s < 0) s = 0;
          if (s > int'(SUM_MAX)) s = int'(SUM_MAX);
          want.group_index   = 3'(k);
          want.allele_sum    = SUM_W'(s);
          want.called_count  = grp_called[k];
          want.inverted      = inv;
          want.last_of_probe = (k == n - 1);
          pending_sums.push_back(want);
        end
      end
      clear_tallies();
    endfunction

    function string fmt(gags_out_t r);
      return $sformatf("grp=%0d sum=%0d called=%0d inv=%0b last=%0b", r.group_index,
                       r.allele_sum, r.called_count, r.inverted, r.last_of_probe);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("MISMATCH @%0t: %s", $time, what);
    endfunction

    function void check_result(gags_out_t got);
      gags_out_t want;
      if (pending_sums.size() == 0) begin
        flag({"result with nothing expected: ", fmt(got)});
        return;
      end
      want = pending_sums.pop_front();
      if (got.group_index !== want.group_index || got.allele_sum !== want.allele_sum ||
          got.called_count !== want.called_count || got.inverted !== want.inverted ||
          got.last_of_probe !== want.last_of_probe)
        flag({"expected ", fmt(want), " got ", fmt(got)});
    endfunction

    function int outstanding();
      return pending_sums.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  gags_in_t              in_data   = '0;
  logic                  out_valid;
  gags_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                cycles  = 0;
  bit                no_gaps = 1'b0;  // set for back-to-back stretches
  allele_sum_checker board   = new();

  genotype_allele_group_summer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a missing result or a stuck busy ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("genotype_allele_group_summer_core_tb: done, errors");
      $finish;
    end
  end

  // Results cannot be stalled: every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  // Present one item, hold it until start && !busy at an edge, then idle for a
  // random gap, which may be empty. With no gap start stays high for the next item.
  task automatic send_subject(input logic [7:0] code, input logic [7:0] grp,
                              input logic last);
    gags_in_t it;
    int       gap;
    it.genotype_code = code;
    it.subject_group = grp;
    it.last_subject  = last;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_subject(it);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted result is back and the sweep is done.
  task automatic settle(input int extra);
    start <= 1'b0;
    while (board.outstanding() != 0 || busy) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Writes all four registers while idle; junk above narrow fields must be dropped.
  task automatic load_config(input logic [31:0] lc, input logic en,
                             input logic [63:0] lab, input logic [NGRP_W-1:0] n);
    settle(SETTLE_CYCLES);
    write_reg(CFG_LEVEL_CODES, {$urandom(), lc});
    write_reg(CFG_SUM_ENABLE, {$urandom(), 31'($urandom()), en});
    write_reg(CFG_GROUP_LABELS, lab);
    write_reg(CFG_GROUPS_IN_USE, {$urandom(), 28'($urandom()), n});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int          ph;
    int          sent;
    int          len;
    int          favored;
    int          lvl;
    int          kk;
    int          i;
    logic        en;
    logic [7:0]  code;
    logic [7:0]  grp;
    logic [31:0] lc;
    logic [63:0] lab;
    logic [3:0]  n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: codes 0..3, all labels 0, two groups.
    // Missing call, each level, unmatched byte, unknown label.
    send_subject(8'h00, 8'h00, 1'b0);
    send_subject(8'h01, 8'h00, 1'b0);
    send_subject(8'h02, 8'h00, 1'b0);
    send_subject(8'h03, 8'h00, 1'b0);
    send_subject(8'h03, 8'h00, 1'b0);
    send_subject(8'hFF, 8'h00, 1'b0);
    send_subject(8'h02, 8'hFF, 1'b0);
    send_subject(8'h01, 8'h00, 1'b1);
    // level-3 calls outnumber level-1: sums get swapped
    send_subject(8'h03, 8'h00, 1'b0);
    send_subject(8'h03, 8'h00, 1'b0);
    send_subject(8'h01, 8'h00, 1'b0);
    send_subject(8'h02, 8'h00, 1'b1);
    // one-subject probe that is missing
    send_subject(8'h00, 8'h00, 1'b1);

    // Level 1 and 2 share a code (2 wins but level-1 count still moves),
    // groups 0 and 5 share label 0x77, groups-in-use above the max.
    load_config(32'hFF55_55AA, 1'b1, 64'h0011_7733_4455_6677, 4'd15);
    send_subject(8'h55, 8'h77, 1'b0);
    send_subject(8'hFF, 8'h00, 1'b0);
    send_subject(8'hAA, 8'h77, 1'b0);
    send_subject(8'hFF, 8'h77, 1'b1);

    // Summing off, groups-in-use 0, levels 1 and 3 share a code.
    load_config(32'h5A11_5A00, 1'b0, 64'h0, 4'd0);
    send_subject(8'h5A, 8'h00, 1'b0);
    send_subject(8'h5A, 8'h00, 1'b1);
    send_subject(8'h00, 8'hFF, 1'b1);

    // A longer probe at full rate, heavy in level 3, so the swap works from
    // large counts.
    load_config(LEVEL_CODES_RST, 1'b1, 64'h0, 4'd1);
    no_gaps = 1'b1;
    repeat (LONG_PROBE) send_subject(8'h03, 8'h00, 1'b0);
    send_subject(8'h01, 8'h00, 1'b1);
    no_gaps = 1'b0;

    // Random probes. Most bytes hit a configured code and most labels hit a group;
    // each probe leans toward one level so inversions happen both ways.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: load_config(32'h0000_0000, 1'b1, '1, 4'd8);  // one code for all levels
        1: load_config('1, 1'b1, '0, 4'd15);
        default: begin
          for (i = 0; i < 4; i++)
            lc[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom());
          for (i = 0; i < 8; i++)
            lab[8*i +: 8] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom());
          n  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
          en = ($urandom_range(0, 3) != 0);
          load_config(lc, en, lab, n);
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len     = $urandom_range(1, 12);
        favored = $urandom_range(0, 3);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) begin
          lvl  = ($urandom_range(0, 1) != 0) ? favored : $urandom_range(0, 3);
          code = ($urandom_range(0, 9) < 8) ? board.level_codes[8*lvl +: 8]
                                            : 8'($urandom());
          kk   = $urandom_range(0, 7);
          grp  = ($urandom_range(0, 9) < 8) ? board.labels[8*kk +: 8] : 8'($urandom());
          // an occasional stray end mark cuts the probe short
          send_subject(code, grp, (i == len - 1) || ($urandom_range(0, 29) == 0));
          sent++;
        end
        if ($urandom_range(0, 7) == 0) settle(0);
      end
      no_gaps = 1'b0;
    end

    settle(SETTLE_CYCLES);
    if (board.errors == 0) begin
      $display("genotype_allele_group_summer_core_tb: done, clean");
    end else begin
      $display("genotype_allele_group_summer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
